// ----- design/cbd_pkg.sv -----
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the correlator bit demodulator
// Configuration bundle, datapath command bundle, register map and the
// elaboration-time sine table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

    // Register map indexes (byte address = 8 * index)
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_STEP_A    = 3'd1;
    localparam logic [2:0] REG_STEP_B    = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_WINDOW    = 3'd5;

    // Register reset values
    localparam logic [31:0] STEP_A_RESET = 32'd42949673;
    localparam logic [31:0] STEP_B_RESET = 32'd107374182;
    localparam logic [15:0] AMPL_RESET   = 16'd256;
    localparam logic [15:0] WINDOW_RESET = 16'd625;

    // pi in Q30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Configuration bundle from the register file
    typedef struct packed {
        logic        mode;
        logic [31:0] step_a;
        logic [31:0] step_b;
        logic [15:0] amplitude;
        logic [47:0] threshold;
        logic [15:0] window_length;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;       // latch accepted sample
        logic carrier_b;  // current step works on carrier b
        logic rom_rd;     // read sine table
        logic ref_ld;     // scale sine by amplitude
        logic mul_ld;     // sample times reference
        logic acc_ld;     // integrate product
        logic met_ld;     // form metric, advance phases and window
        logic out_ld;     // decide and load result register
    } cmd_t;

    // Sine table entry k for a table of 2^tb entries, signed Q1.15.
    // Quarter wave from a Taylor series to x^13, the rest by symmetry.
    function automatic logic [15:0] sine_value(input int unsigned k, input int unsigned tb);
        int unsigned       q;
        int unsigned       r;
        int unsigned       quarter;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            v;
        quarter = 32'd1 << (tb - 2);
        q = k >> (tb - 2);
        r = k & (quarter - 1);
        if (q[0]) begin
            r = quarter - r;
        end
        x    = (longint'(r) * PI_Q30) >> (tb - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32767) begin
            v = 64'sd32767;
        end
        return q[1] ? 16'(-v) : 16'(v);
    endfunction

endpackage

`default_nettype wire

// ----- design/cbd_regs.sv -----
// ----------------------------------------------------------------------------
// cbd_regs: configuration register file
// APB-style write/read port, 64-bit data, registers at 8-byte spacing.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_regs (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic      [63:0]  prdata,
    output logic              pready,
    output cbd_pkg::cfg_t     cfg
);

    logic         mode_reg;
    logic [31:0]  step_a_reg;
    logic [31:0]  step_b_reg;
    logic [15:0]  amplitude_reg;
    logic [47:0]  threshold_reg;
    logic [15:0]  window_reg;
    logic [2:0]   index;
    logic         wr_en;

    assign pready = 1'b1;
    assign index  = paddr[5:3];
    assign wr_en  = psel & penable & pwrite;

    // register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            step_a_reg    <= cbd_pkg::STEP_A_RESET;
            step_b_reg    <= cbd_pkg::STEP_B_RESET;
            amplitude_reg <= cbd_pkg::AMPL_RESET;
            threshold_reg <= '0;
            window_reg    <= cbd_pkg::WINDOW_RESET;
        end else if (wr_en) begin
            unique case (index)
                cbd_pkg::REG_MODE:      mode_reg      <= pwdata[0];
                cbd_pkg::REG_STEP_A:    step_a_reg    <= pwdata[31:0];
                cbd_pkg::REG_STEP_B:    step_b_reg    <= pwdata[31:0];
                cbd_pkg::REG_AMPLITUDE: amplitude_reg <= pwdata[15:0];
                cbd_pkg::REG_THRESHOLD: threshold_reg <= pwdata[47:0];
                cbd_pkg::REG_WINDOW:    window_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (index)
            cbd_pkg::REG_MODE:      prdata = {63'd0, mode_reg};
            cbd_pkg::REG_STEP_A:    prdata = {32'd0, step_a_reg};
            cbd_pkg::REG_STEP_B:    prdata = {32'd0, step_b_reg};
            cbd_pkg::REG_AMPLITUDE: prdata = {48'd0, amplitude_reg};
            cbd_pkg::REG_THRESHOLD: prdata = {{16{threshold_reg[47]}}, threshold_reg};
            cbd_pkg::REG_WINDOW:    prdata = {48'd0, window_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.mode          = mode_reg;
    assign cfg.step_a        = step_a_reg;
    assign cfg.step_b        = step_b_reg;
    assign cfg.amplitude     = amplitude_reg;
    assign cfg.threshold     = threshold_reg;
    assign cfg.window_length = window_reg;

endmodule

`default_nettype wire

// ----- design/cbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbd_ctrl: sequencing state machine
// Steps one item through sine read, scaling, product and integration for
// carrier a then carrier b, then metric and decision; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_ctrl (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output cbd_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ROM_A = 4'd1;
    localparam logic [3:0] ST_REF_A = 4'd2;
    localparam logic [3:0] ST_MUL_A = 4'd3;
    localparam logic [3:0] ST_ACC_A = 4'd4;
    localparam logic [3:0] ST_ROM_B = 4'd5;
    localparam logic [3:0] ST_REF_B = 4'd6;
    localparam logic [3:0] ST_MUL_B = 4'd7;
    localparam logic [3:0] ST_ACC_B = 4'd8;
    localparam logic [3:0] ST_MET   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take = s_valid;
                if (s_valid) begin
                    state_next = ST_ROM_A;
                end
            end
            ST_ROM_A: begin
                cmd.rom_rd = 1'b1;
                state_next = ST_REF_A;
            end
            ST_REF_A: begin
                cmd.ref_ld = 1'b1;
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                cmd.mul_ld = 1'b1;
                state_next = ST_ACC_A;
            end
            ST_ACC_A: begin
                cmd.acc_ld = 1'b1;
                state_next = ST_ROM_B;
            end
            ST_ROM_B: begin
                cmd.carrier_b = 1'b1;
                cmd.rom_rd    = 1'b1;
                state_next    = ST_REF_B;
            end
            ST_REF_B: begin
                cmd.carrier_b = 1'b1;
                cmd.ref_ld    = 1'b1;
                state_next    = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.carrier_b = 1'b1;
                cmd.mul_ld    = 1'b1;
                state_next    = ST_ACC_B;
            end
            ST_ACC_B: begin
                cmd.carrier_b = 1'b1;
                cmd.acc_ld    = 1'b1;
                state_next    = ST_MET;
            end
            ST_MET: begin
                cmd.met_ld = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.out_ld = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (cmd.out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/cbd_datapath.sv -----
// ----------------------------------------------------------------------------
// cbd_datapath: correlator datapath
// Phase accumulators, sine table, shared amplitude and sample multipliers,
// saturating integrators, window counter, metric and decision registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_datapath #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int ACCUM_BITS      = 48
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cbd_pkg::cmd_t      cmd,
    input  wire cbd_pkg::cfg_t      cfg,
    input  wire logic signed [15:0] s_sample,
    output logic                    m_decided_bit,
    output logic signed [47:0]      m_metric,
    output logic                    m_window_end
);

    localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
    localparam int REF_W      = 25;
    localparam int PROD_W     = SAMPLE_BITS + REF_W;
    localparam int SUM_W      = ((ACCUM_BITS > PROD_W) ? ACCUM_BITS : PROD_W) + 1;
    localparam int CMP_W      = (ACCUM_BITS > 48) ? ACCUM_BITS : 48;

    localparam logic signed [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
    localparam logic signed [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};

    // state
    logic [31:0]                  phase_a_reg;
    logic [31:0]                  phase_b_reg;
    logic [15:0]                  pos_reg;
    logic signed [ACCUM_BITS-1:0] integ_a_reg;
    logic signed [ACCUM_BITS-1:0] integ_b_reg;

    // payload
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [15:0]            sine_reg;
    logic signed [REF_W-1:0]       ref_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACCUM_BITS-1:0]  metric_reg;
    logic                          end_reg;
    logic                          bit_reg;
    logic signed [47:0]            metric_out_reg;
    logic                          end_out_reg;

    // combinational
    logic signed [15:0]            sine_rom [TABLE_SIZE];
    logic [SINE_TABLE_BITS-1:0]    rom_idx;
    logic signed [16:0]            amp_s;
    logic signed [32:0]            scaled;
    logic signed [32:0]            scaled_rnd;
    logic signed [ACCUM_BITS-1:0]  acc_base;
    logic signed [SUM_W-1:0]       acc_sum;
    logic [SUM_W-ACCUM_BITS:0]     acc_top;
    logic signed [ACCUM_BITS-1:0]  acc_sat;
    logic signed [ACCUM_BITS:0]    diff;
    logic signed [ACCUM_BITS-1:0]  diff_sat;
    logic signed [ACCUM_BITS-1:0]  metric_next;
    logic [16:0]                   pos_inc;
    logic [16:0]                   win_len;
    logic                          win_end;
    logic signed [CMP_W-1:0]       metric_ext;
    logic signed [CMP_W-1:0]       thresh_ext;

    // narrow samples keep their low SAMPLE_BITS bits; wider samples are zero-extended
    if (SAMPLE_BITS <= 16) begin : g_samp_narrow
        assign sample_in = s_sample[SAMPLE_BITS-1:0];
    end else begin : g_samp_wide
        assign sample_in = {{(SAMPLE_BITS-16){1'b0}}, s_sample};
    end

    // constant sine table
    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
        assign sine_rom[k] = cbd_pkg::sine_value(k, SINE_TABLE_BITS);
    end

    assign rom_idx = cmd.carrier_b ? phase_b_reg[31 -: SINE_TABLE_BITS]
                                   : phase_a_reg[31 -: SINE_TABLE_BITS];

    // amplitude * sine, rounded back to Q15
    assign amp_s      = {1'b0, cfg.amplitude};
    assign scaled     = amp_s * sine_reg;
    assign scaled_rnd = scaled + 33'sd128;

    // saturating integrate; window start restarts from the product
    assign acc_base = (pos_reg == 16'd0) ? '0 : (cmd.carrier_b ? integ_b_reg : integ_a_reg);
    assign acc_sum  = SUM_W'(acc_base) + SUM_W'(prod_reg);
    assign acc_top  = acc_sum[SUM_W-1:ACCUM_BITS-1];
    always_comb begin
        if ((&acc_top) || !(|acc_top)) begin
            acc_sat = acc_sum[ACCUM_BITS-1:0];
        end else if (acc_sum[SUM_W-1]) begin
            acc_sat = ACC_MIN;
        end else begin
            acc_sat = ACC_MAX;
        end
    end

    // FSK difference, saturated
    assign diff = {integ_b_reg[ACCUM_BITS-1], integ_b_reg}
                - {integ_a_reg[ACCUM_BITS-1], integ_a_reg};
    always_comb begin
        if (diff[ACCUM_BITS] == diff[ACCUM_BITS-1]) begin
            diff_sat = diff[ACCUM_BITS-1:0];
        end else if (diff[ACCUM_BITS]) begin
            diff_sat = ACC_MIN;
        end else begin
            diff_sat = ACC_MAX;
        end
    end
    assign metric_next = cfg.mode ? diff_sat : integ_a_reg;

    // window end; zero length acts as one
    assign pos_inc = {1'b0, pos_reg} + 17'd1;
    assign win_len = (cfg.window_length == 16'd0) ? 17'd1 : {1'b0, cfg.window_length};
    assign win_end = (pos_inc >= win_len);

    // decision
    assign metric_ext = CMP_W'(metric_reg);
    assign thresh_ext = CMP_W'($signed(cfg.threshold));

    // correlator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_a_reg <= '0;
            phase_b_reg <= '0;
            pos_reg     <= '0;
            integ_a_reg <= '0;
            integ_b_reg <= '0;
        end else begin
            if (cmd.acc_ld && !cmd.carrier_b) begin
                integ_a_reg <= acc_sat;
            end
            if (cmd.acc_ld && cmd.carrier_b) begin
                integ_b_reg <= acc_sat;
            end
            if (cmd.met_ld) begin
                phase_a_reg <= phase_a_reg + cfg.step_a;
                phase_b_reg <= phase_b_reg + cfg.step_b;
                pos_reg     <= win_end ? 16'd0 : pos_inc[15:0];
            end
        end
    end

    // working and result registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sample_reg <= sample_in;
        end
        if (cmd.rom_rd) begin
            sine_reg <= sine_rom[rom_idx];
        end
        if (cmd.ref_ld) begin
            ref_reg <= scaled_rnd[32:8];
        end
        if (cmd.mul_ld) begin
            prod_reg <= sample_reg * ref_reg;
        end
        if (cmd.met_ld) begin
            metric_reg <= metric_next;
            end_reg    <= win_end;
        end
        if (cmd.out_ld) begin
            bit_reg        <= (metric_ext >= thresh_ext);
            metric_out_reg <= metric_ext[47:0];
            end_out_reg    <= end_reg;
        end
    end

    assign m_decided_bit = bit_reg;
    assign m_metric      = metric_out_reg;
    assign m_window_end  = end_out_reg;

endmodule

`default_nettype wire

// ----- design/correlator_bit_demodulator.sv -----
// A result becomes valid once its item has stepped through sine read, scaling, product
// and integration for carrier a then carrier b, then metric and output. Items do not overlap:
// the shared sine table, amplitude multiplier and sample multiplier serve a, then b, in turn.
// Input ready is high only in idle; a result still waiting at the output stage holds it there.
// Reset (aresetn low, synchronous) clears phases, integrators, window position
// and handshake state, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// correlator_bit_demodulator: coherent integrate-and-dump bit demodulator
// Correlates each sample against one or two reference carriers, integrates
// over a window and decides one bit per sample against a threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module correlator_bit_demodulator #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int ACCUM_BITS      = 48
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready,
    // sample items
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_sample,
    // result items
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_decided_bit,
    output logic signed [47:0]      m_metric,
    output logic                    m_window_end
);

    cbd_pkg::cfg_t cfg;
    cbd_pkg::cmd_t cmd;

    cbd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    cbd_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ACCUM_BITS      (ACCUM_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg           (cfg),
        .s_sample      (s_sample),
        .m_decided_bit (m_decided_bit),
        .m_metric      (m_metric),
        .m_window_end  (m_window_end)
    );

endmodule

`default_nettype wire
